// File: rtl/core/msp_pkg.sv
package msp_pkg;

    // Residue and result width
    localparam int unsigned WORD_W = 64;

    // n = 4294967291 * 4294967279
    localparam logic [WORD_W-1:0] MODULUS = 64'd18446743979220271189;

    // Added when the low half of a round result is 0 or 1 and the upper half is not 0
    localparam logic [WORD_W-1:0] KICK = 64'd429496737;

    // Request codes on the mode field
    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_RESEED   = 1'b1;

    // Last round index per output width
    localparam logic [2:0] LAST_ROUND_NARROW = 3'd3;
    localparam logic [2:0] LAST_ROUND_WIDE   = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DOUBLE,
        ST_ADD,
        ST_ROUND_END,
        ST_FINISH
    } msp_state_t;

endpackage

// File: rtl/core/modular_squaring_prng_unit.sv
// A generate word runs R rounds before its result is loaded; R = 4 rounds at 32-bit width
// or 8 at 64-bit width. A round is one reduce step, 64 bits of bit-serial shift-and-add
// squaring with a double step and an add step per bit, and one round-end step.
// The input stalls while a generate word is in progress; while idle, a reseed word is taken
// every cycle. The output register lets the next word enter while a result waits; a finished
// word stalls the input until that register is free. Reset zeroes residue and output width.
module modular_squaring_prng_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic [msp_pkg::WORD_W-1:0] seed_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [msp_pkg::WORD_W-1:0] random_value,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);
    import msp_pkg::*;

    msp_state_t        state_reg, state_next;
    logic              width_reg;
    logic              wide_reg;
    logic [WORD_W-1:0] residue_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] bits_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [5:0]        bit_cnt_reg;
    logic [2:0]        round_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;

    logic              in_take;
    logic              out_take;
    logic              out_load;
    logic              last_round;
    logic [WORD_W-1:0] add_op_b;
    logic [WORD_W:0]   add_sum;
    logic [WORD_W+1:0] add_diff;
    logic [WORD_W-1:0] add_res;
    logic [WORD_W:0]   red_diff;
    logic [WORD_W-1:0] red_res;
    logic [WORD_W-1:0] kicked;

    assign in_take    = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign last_round = (round_reg == (wide_reg ? LAST_ROUND_WIDE : LAST_ROUND_NARROW));
    assign cfg_ready  = 1'b1;
    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;

    // Shared modular adder: r + b mod n, both operands below n
    always_comb
    begin
        case (state_reg)
            ST_DOUBLE: add_op_b = r_reg;
            ST_ADD:    add_op_b = bits_reg[WORD_W-1] ? a_reg : '0;
            default:   add_op_b = '0;
        endcase
        add_sum  = {1'b0, r_reg} + {1'b0, add_op_b};
        add_diff = {1'b0, add_sum} - {2'b00, MODULUS};
        add_res  = add_diff[WORD_W+1] ? add_sum[WORD_W-1:0] : add_diff[WORD_W-1:0];
    end

    // Operand reduction below n, then the low-half kick
    always_comb
    begin
        red_diff = {1'b0, residue_reg} - {1'b0, MODULUS};
        red_res  = red_diff[WORD_W] ? residue_reg : red_diff[WORD_W-1:0];
        if ((r_reg[31:1] == 31'd0) && (r_reg[WORD_W-1:32] != 32'd0))
        begin
            kicked = r_reg + KICK;
        end
        else
        begin
            kicked = r_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (mode == MODE_GENERATE))
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:    state_next = ST_DOUBLE;
            ST_DOUBLE:    state_next = ST_ADD;
            ST_ADD:       state_next = (bit_cnt_reg == 6'd0) ? ST_ROUND_END : ST_DOUBLE;
            ST_ROUND_END: state_next = last_round ? ST_FINISH : ST_REDUCE;
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_FINISH: out_load = !out_valid_reg || !out_stall;
            default:
            begin
                in_stall = 1'b1;
                out_load = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 1'b0;
            residue_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
            if (in_take && (mode == MODE_RESEED))
            begin
                residue_reg <= width_reg ? seed_value : {32'd0, seed_value[31:0]};
            end
            else if (state_reg == ST_ROUND_END)
            begin
                residue_reg <= kicked;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Bit-serial squaring datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    wide_reg  <= width_reg;
                    acc_reg   <= '0;
                    round_reg <= 3'd0;
                end
            end
            ST_REDUCE:
            begin
                a_reg       <= red_res;
                bits_reg    <= red_res;
                r_reg       <= '0;
                bit_cnt_reg <= 6'd63;
            end
            ST_DOUBLE:
            begin
                r_reg <= add_res;
            end
            ST_ADD:
            begin
                r_reg       <= add_res;
                bits_reg    <= {bits_reg[WORD_W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg - 6'd1;
            end
            ST_ROUND_END:
            begin
                acc_reg   <= {acc_reg[WORD_W-9:0], kicked[7:0]};
                round_reg <= round_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= acc_reg;
        end
    end

    // The squaring accumulator stays reduced below n
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND_END) |-> (r_reg < MODULUS))
        else $error("round result not reduced below modulus");

    // The multiplicand is reduced before the bit loop
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DOUBLE) || (state_reg == ST_ADD)) |-> (a_reg < MODULUS))
        else $error("multiplicand not reduced below modulus");

    // A waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_valid_reg && out_stall) |=> (state_reg == ST_FINISH))
        else $error("finished word left while output register full");

    // A generate word starts the round sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (mode == MODE_GENERATE)) |=> (state_reg == ST_REDUCE) && (round_reg == 3'd0))
        else $error("generate word did not start rounds");

endmodule

// File: sim/tb_modular_squaring_prng_unit.sv
`timescale 1ns / 1ps

module tb_modular_squaring_prng_unit;

    localparam int unsigned W = msp_pkg::WORD_W;

    // n = p * q, and the bump added when a round lands on 0 or 1 in its low half with a nonzero high half
    localparam logic [W-1:0] PRIME_P = 64'd4294967291;
    localparam logic [W-1:0] PRIME_Q = 64'd4294967279;
    localparam logic [W-1:0] MOD_N   = PRIME_P * PRIME_Q;
    localparam logic [W-1:0] BUMP    = 64'd429496737;

    // idle wait after all draws are back, before a width write
    localparam int SETTLE_CYCLES = 1100;
    localparam int CYCLE_LIMIT   = 8000000;
    localparam int NUM_DIRECTED  = 24;

    typedef struct packed {
        logic         wide;
        logic         mode;
        logic [W-1:0] seed;
        logic         known;
        logic [W-1:0] word;
    } directed_row_t;

    logic         clk        = 1'b0;
    logic         rst_n      = 1'b0;
    logic         in_valid   = 1'b0;
    logic         in_stall;
    logic         mode       = msp_pkg::MODE_GENERATE;
    logic [W-1:0] seed_value = '0;
    logic         out_valid;
    logic         out_stall  = 1'b0;
    logic [W-1:0] random_value;
    logic         cfg_valid  = 1'b0;
    logic         cfg_ready;
    logic         cfg_data   = 1'b0;

    // mirror of the generator state
    logic [W-1:0] residue_mirror = '0;
    logic         wide_mirror    = 1'b0;
    logic [W-1:0] pending_draws[$];

    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    int           mismatches     = 0;
    int           cycle_count    = 0;
    logic [W-1:0] oldest_draw;

    modular_squaring_prng_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("modular_squaring_prng_unit: mismatch");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // result check; inputs only move at rising edges, so the falling edge sees settled values
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("random_value: no word expected, got %h", random_value);
                mismatches++;
            end
            else
            begin
                oldest_draw = pending_draws.pop_front();
                if (random_value !== oldest_draw)
                begin
                    $error("random_value: expected %h, got %h", oldest_draw, random_value);
                    mismatches++;
                end
            end
        end
    end

    // one round: x*x mod n, then the bump when the low half is 0 or 1 and the high half is not 0
    function automatic logic [W-1:0] square_round(input logic [W-1:0] x);
        logic [2*W-1:0] prod;
        logic [2*W-1:0] rem;
        logic [W-1:0]   r;
        if (x >= MOD_N)
            x = x - MOD_N;
        prod = {{W{1'b0}}, x} * {{W{1'b0}}, x};
        rem  = prod % {{W{1'b0}}, MOD_N};
        r    = rem[W-1:0];
        if (r[31:0] <= 32'd1 && r[63:32] != 32'd0)
            r = r + BUMP;
        return r;
    endfunction

    // advance the mirror for one accepted word and queue the draw it produces
    task automatic track_word(input logic m, input logic [W-1:0] s,
                              input logic known, input logic [W-1:0] typed);
        logic [W-1:0] acc;
        int           rounds;
        acc = '0;
        if (m == msp_pkg::MODE_RESEED)
        begin
            residue_mirror = wide_mirror ? s : {32'd0, s[31:0]};
        end
        else
        begin
            rounds = wide_mirror ? 8 : 4;
            for (int i = 0; i < rounds; i++)
            begin
                residue_mirror = square_round(residue_mirror);
                acc = {acc[W-9:0], residue_mirror[7:0]};
            end
            pending_draws.push_back(known ? typed : acc);
        end
    endtask

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_word(input logic m, input logic [W-1:0] s,
                             input logic known, input logic [W-1:0] typed);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        seed_value <= s;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        track_word(m, s, known, typed);
        @(posedge clk);
    endtask

    // stop sending, let every draw come back, then give a reseed time to retire
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        wide_mirror = w;
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [W-1:0] pick_seed();
        logic [W-1:0] s;
        case ($urandom_range(9))
            0: s = W'($urandom_range(1));
            1: s = W'($urandom_range(255));
            2: s = 64'd1 << $urandom_range(63);
            3: s = MOD_N - 64'd8 + W'($urandom_range(16));
            4: s = 64'hFFFF_FFFF_FFFF_FFFF - W'($urandom_range(15));
            5: s = {32'd0, 32'($urandom)};
            default: s = {32'($urandom), 32'($urandom)};
        endcase
        return s;
    endfunction

    initial
    begin
        directed_row_t dir_rows [NUM_DIRECTED];
        int            src_pct  [4];
        int            sink_pct [4];
        int            count;
        logic          w;

        src_pct  = '{0, 75, 0, 37};
        sink_pct = '{0, 0, 75, 37};

        // narrow width: reset state, stuck seeds, upper seed bits dropped, bump on 2^16
        dir_rows[0]  = '{1'b0, msp_pkg::MODE_GENERATE, 64'd0, 1'b1, 64'd0};
        dir_rows[1]  = '{1'b0, msp_pkg::MODE_RESEED, 64'd1, 1'b0, 64'd0};
        dir_rows[2]  = '{1'b0, msp_pkg::MODE_GENERATE, 64'd0, 1'b1, 64'h0101_0101};
        dir_rows[3]  = '{1'b0, msp_pkg::MODE_RESEED, 64'hFFFF_FFFF_0000_0000, 1'b0, 64'd0};
        dir_rows[4]  = '{1'b0, msp_pkg::MODE_GENERATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0};
        dir_rows[5]  = '{1'b0, msp_pkg::MODE_RESEED, 64'hFFFF_FFFF_0000_0001, 1'b0, 64'd0};
        dir_rows[6]  = '{1'b0, msp_pkg::MODE_GENERATE, 64'd0, 1'b1, 64'h0101_0101};
        dir_rows[7]  = '{1'b0, msp_pkg::MODE_RESEED, 64'h0000_0000_0001_0000, 1'b0, 64'd0};
        dir_rows[8]  = '{1'b0, msp_pkg::MODE_GENERATE, 64'd0, 1'b0, 64'd0};
        dir_rows[9]  = '{1'b0, msp_pkg::MODE_RESEED, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'd0};
        dir_rows[10] = '{1'b0, msp_pkg::MODE_GENERATE, 64'd0, 1'b0, 64'd0};
        dir_rows[11] = '{1'b0, msp_pkg::MODE_GENERATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0};
        // wide width: residue carried over, seeds at and above n, near n
        dir_rows[12] = '{1'b1, msp_pkg::MODE_GENERATE, 64'd0, 1'b0, 64'd0};
        dir_rows[13] = '{1'b1, msp_pkg::MODE_RESEED, 64'd1, 1'b0, 64'd0};
        dir_rows[14] = '{1'b1, msp_pkg::MODE_GENERATE, 64'd0, 1'b1, 64'h0101_0101_0101_0101};
        dir_rows[15] = '{1'b1, msp_pkg::MODE_RESEED, MOD_N, 1'b0, 64'd0};
        dir_rows[16] = '{1'b1, msp_pkg::MODE_GENERATE, 64'd0, 1'b1, 64'd0};
        dir_rows[17] = '{1'b1, msp_pkg::MODE_RESEED, MOD_N + 64'd1, 1'b0, 64'd0};
        dir_rows[18] = '{1'b1, msp_pkg::MODE_GENERATE, 64'd0, 1'b1, 64'h0101_0101_0101_0101};
        dir_rows[19] = '{1'b1, msp_pkg::MODE_RESEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0};
        dir_rows[20] = '{1'b1, msp_pkg::MODE_GENERATE, 64'd0, 1'b0, 64'd0};
        dir_rows[21] = '{1'b1, msp_pkg::MODE_RESEED, MOD_N - 64'd1, 1'b0, 64'd0};
        dir_rows[22] = '{1'b1, msp_pkg::MODE_GENERATE, 64'd0, 1'b0, 64'd0};
        // back to narrow on the shared residue
        dir_rows[23] = '{1'b0, msp_pkg::MODE_GENERATE, 64'd0, 1'b0, 64'd0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (dir_rows[i].wide != wide_mirror)
            begin
                settle_block();
                write_width(dir_rows[i].wide);
            end
            send_word(dir_rows[i].mode, dir_rows[i].seed, dir_rows[i].known, dir_rows[i].word);
        end

        // random phases: each idle pattern at both widths
        for (int ph = 0; ph < 8; ph++)
        begin
            w = ph[0];
            count = w ? 80 : 300;
            settle_block();
            write_width(w);
            src_idle_pct   = src_pct[ph / 2];
            sink_stall_pct = sink_pct[ph / 2];
            for (int i = 0; i < count; i++)
            begin
                // sender holds off once per phase until all draws are back
                if (i == count / 2)
                    settle_block();
                send_word(($urandom_range(99) < 45) ? msp_pkg::MODE_RESEED
                                                    : msp_pkg::MODE_GENERATE,
                          pick_seed(), 1'b0, 64'd0);
            end
        end

        in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("modular_squaring_prng_unit: match");
        else
            $display("modular_squaring_prng_unit: mismatch");
        $finish;
    end

endmodule
